// File: src/label_value_text_telemetry_parser_assert.svh
// Assertion macros shared by the telemetry parser RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef LABEL_VALUE_TEXT_TELEMETRY_PARSER_ASSERT_SVH
`define LABEL_VALUE_TEXT_TELEMETRY_PARSER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define LVTP_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lvtp assertion failed");

// Next-cycle implication, off during reset.
`define LVTP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lvtp assertion failed");

`endif

// File: src/lvtp_pkg.sv
// Shared types, character codes, label table and helpers of the telemetry parser.
// Depends on nothing.
package lvtp_pkg;

   localparam int LABEL_TOTAL = 14;
   localparam int TABLE_CHARS = 4;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF_HEX = 8'h66;
   localparam logic [7:0] CH_LX    = 8'h78;

   localparam logic [3:0] CODE_CURRENT = 4'd3;
   localparam logic [3:0] CODE_PID     = 4'd12;
   localparam logic [3:0] CODE_SERIAL  = 4'd13;

   // number reader phases
   localparam logic [2:0] PH_SKIP   = 3'd0;
   localparam logic [2:0] PH_SIGN   = 3'd1;
   localparam logic [2:0] PH_DIGITS = 3'd2;
   localparam logic [2:0] PH_STOP   = 3'd3;
   localparam logic [2:0] PH_ZERO   = 3'd4;
   localparam logic [2:0] PH_PREFIX = 3'd5;

   localparam logic [2:0] LABEL_LEN [LABEL_TOTAL] = '{
      3'd1, 3'd3, 3'd3, 3'd1, 3'd3, 3'd3, 3'd3,
      3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd3, 3'd4
   };

   localparam logic [7:0] LABEL_CHR [LABEL_TOTAL][TABLE_CHARS] = '{
      '{"V", 8'h00, 8'h00, 8'h00},
      '{"V", "P", "V", 8'h00},
      '{"P", "P", "V", 8'h00},
      '{"I", 8'h00, 8'h00, 8'h00},
      '{"H", "1", "9", 8'h00},
      '{"H", "2", "0", 8'h00},
      '{"H", "2", "1", 8'h00},
      '{"H", "2", "2", 8'h00},
      '{"H", "2", "3", 8'h00},
      '{"E", "R", "R", 8'h00},
      '{"C", "S", 8'h00, 8'h00},
      '{"F", "W", 8'h00, 8'h00},
      '{"P", "I", "D", 8'h00},
      '{"S", "E", "R", "#"}
   };

   typedef struct packed {
      logic       fire;
      logic [7:0] text_byte;
   } step_type;

   typedef struct packed {
      logic [3:0]         field_code;
      logic signed [31:0] field_value;
   } result_type;

   function automatic logic is_hex_code(input logic [3:0] code);
      return (code == CODE_PID) || (code == CODE_SERIAL);
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
   endfunction

   // {valid, digit value}
   function automatic logic [4:0] digit_of(input logic [7:0] c, input logic hex);
      logic [7:0] t;
      t = 8'h00;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         t = c - CH_ZERO;
         return {1'b1, t[3:0]};
      end
      if (hex && c >= CH_LA && c <= CH_LF_HEX) begin
         t = c - CH_LA + 8'd10;
         return {1'b1, t[3:0]};
      end
      if (hex && c >= CH_UA && c <= CH_UF) begin
         t = c - CH_UA + 8'd10;
         return {1'b1, t[3:0]};
      end
      return 5'd0;
   endfunction

endpackage

// File: src/lvtp_if.sv
// Valid/ready channel interfaces of the telemetry parser: text bytes in, fields out.
// Depends on nothing.
interface lvtp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink (input valid, input text_byte, output ready);
endinterface

interface lvtp_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         field_code;
   logic signed [31:0] field_value;

   modport source (output valid, output field_code, output field_value, input ready);
   modport sink (input valid, input field_code, input field_value, output ready);
endinterface

// File: src/label_value_text_telemetry_parser.sv
// Channel   | Dir | Payload                        | Transfer when
// req_bus   | in  | text_byte[7:0]                 | valid && ready
// rsp_bus   | out | field_code[3:0], field_value   | valid && ready
//
// One byte per cycle sustained unless rsp_bus stalls: input register, parse logic,
// result register. A field enters the result register as its closing byte leaves
// the input register. Reset is synchronous and returns the parser to the start of
// a text at once. A stalled result holds the parse step; req_bus keeps taking bytes
// while the input register is empty or is being drained in the same cycle.
// Top level of the label/value telemetry parser; depends on lvtp_pkg, lvtp_if and
// the lvtp_in_reg, lvtp_parse_core and lvtp_out_reg modules.
module label_value_text_telemetry_parser #(
   parameter int LABEL_CHARS = 4
) (
   input logic         clock,
   input logic         reset,
   lvtp_req_if.sink    req_bus,
   lvtp_rsp_if.source  rsp_bus
);

   lvtp_pkg::step_type   step;
   lvtp_pkg::result_type result;
   lvtp_pkg::result_type rsp_data;
   logic                 emit;
   logic                 out_free;

   lvtp_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_text_byte (req_bus.text_byte),
      .req_ready     (req_bus.ready),
      .out_free      (out_free),
      .step          (step)
   );

   lvtp_parse_core #(
      .LABEL_CHARS (LABEL_CHARS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .emit   (emit),
      .result (result)
   );

   lvtp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .result    (result),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_data  (rsp_data),
      .out_free  (out_free)
   );

   assign rsp_bus.field_code  = rsp_data.field_code;
   assign rsp_bus.field_value = rsp_data.field_value;

endmodule

// File: src/lvtp_in_reg.sv
// Input register of the telemetry parser: holds one text byte until the core takes it.
// Depends on lvtp_pkg.
module lvtp_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [7:0]        req_text_byte,
   output logic              req_ready,
   input  logic              out_free,
   output lvtp_pkg::step_type step
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       fire;
   logic       accept;

   assign fire      = valid_ff && out_free;
   assign req_ready = !valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (accept) begin
         valid_in = 1'b1;
         byte_in  = req_text_byte;
      end else if (fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign step.fire      = fire;
   assign step.text_byte = byte_ff;

endmodule

// File: src/lvtp_parse_core.sv
// Token, label and number state of the telemetry parser; one byte per step.
// Depends on lvtp_pkg and the assertion macro header.
`include "label_value_text_telemetry_parser_assert.svh"

module lvtp_parse_core #(
   parameter int LABEL_CHARS = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  lvtp_pkg::step_type  step,
   output logic                emit,
   output lvtp_pkg::result_type result
);

   localparam int CW = $clog2(LABEL_CHARS + 2);
   localparam int IW = $clog2(LABEL_CHARS);

   logic          inside_ff, inside_in;
   logic          expecting_ff, expecting_in;
   logic [3:0]    pending_ff, pending_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   acc_ff, acc_in;
   logic          neg_ff, neg_in;
   logic [2:0]    phase_ff, phase_in;
   logic [7:0]    store_ff [LABEL_CHARS];

   logic          store_we;
   logic [IW-1:0] store_idx;
   logic          match_hit;
   logic [3:0]    match_code;
   logic          hex;
   logic [31:0]   value_signed;

   assign hex = lvtp_pkg::is_hex_code(pending_ff);

   // first table entry wins: scan downward so lower codes overwrite
   always_comb begin
      logic same;
      match_hit  = 1'b0;
      match_code = 4'd0;
      for (int i = lvtp_pkg::LABEL_TOTAL - 1; i >= 0; i--) begin
         same = (count_ff == CW'(lvtp_pkg::LABEL_LEN[i]));
         for (int k = 0; k < lvtp_pkg::TABLE_CHARS; k++) begin
            if (k < int'(lvtp_pkg::LABEL_LEN[i]) &&
                store_ff[k] != lvtp_pkg::LABEL_CHR[i][k]) begin
               same = 1'b0;
            end
         end
         if (same) begin
            match_hit  = 1'b1;
            match_code = 4'(i);
         end
      end
   end

   always_comb begin
      logic [7:0]    c;
      logic [31:0]   cur_acc;
      logic          cur_neg;
      logic [2:0]    cur_phase;
      logic [CW-1:0] cur_count;
      logic [4:0]    dg;
      logic [31:0]   scaled;
      logic [31:0]   taken;
      c         = step.text_byte;
      cur_acc   = acc_ff;
      cur_neg   = neg_ff;
      cur_phase = phase_ff;
      cur_count = count_ff;
      inside_in    = inside_ff;
      expecting_in = expecting_ff;
      pending_in   = pending_ff;
      count_in     = count_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      phase_in     = phase_ff;
      store_we     = 1'b0;
      emit         = 1'b0;
      dg           = lvtp_pkg::digit_of(c, hex);
      scaled       = 32'd0;
      taken        = 32'd0;
      if (step.fire) begin
         if (c == lvtp_pkg::CH_NUL || c == lvtp_pkg::CH_LF || c == lvtp_pkg::CH_TAB) begin
            // close the current token
            if (inside_ff) begin
               inside_in = 1'b0;
               if (expecting_ff) begin
                  emit         = 1'b1;
                  expecting_in = 1'b0;
               end else if (match_hit) begin
                  pending_in   = match_code;
                  expecting_in = 1'b1;
               end
            end
            if (c == lvtp_pkg::CH_NUL) begin
               inside_in    = 1'b0;
               expecting_in = 1'b0;
            end
         end else begin
            if (!inside_ff) begin
               inside_in = 1'b1;
               if (expecting_ff) begin
                  cur_acc   = 32'd0;
                  cur_neg   = 1'b0;
                  cur_phase = lvtp_pkg::PH_SKIP;
               end else begin
                  cur_count = '0;
               end
            end
            if (expecting_ff) begin
               scaled = hex ? {cur_acc[27:0], 4'b0000}
                            : ({cur_acc[28:0], 3'b000} + {cur_acc[30:0], 1'b0});
               taken  = scaled + {28'd0, dg[3:0]};
               acc_in   = cur_acc;
               neg_in   = cur_neg;
               phase_in = cur_phase;
               unique case (cur_phase)
                  lvtp_pkg::PH_SKIP, lvtp_pkg::PH_SIGN: begin
                     if (cur_phase == lvtp_pkg::PH_SKIP && lvtp_pkg::is_blank(c)) begin
                        phase_in = cur_phase;
                     end else if (cur_phase == lvtp_pkg::PH_SKIP &&
                                  (c == lvtp_pkg::CH_PLUS || c == lvtp_pkg::CH_MINUS)) begin
                        neg_in   = (c == lvtp_pkg::CH_MINUS);
                        phase_in = lvtp_pkg::PH_SIGN;
                     end else if (hex && c == lvtp_pkg::CH_ZERO) begin
                        phase_in = lvtp_pkg::PH_ZERO;
                     end else if (dg[4]) begin
                        acc_in   = taken;
                        phase_in = lvtp_pkg::PH_DIGITS;
                     end else begin
                        phase_in = lvtp_pkg::PH_STOP;
                     end
                  end
                  lvtp_pkg::PH_ZERO: begin
                     if (c == lvtp_pkg::CH_LX || c == lvtp_pkg::CH_UX) begin
                        phase_in = lvtp_pkg::PH_PREFIX;
                     end else if (dg[4]) begin
                        acc_in   = taken;
                        phase_in = lvtp_pkg::PH_DIGITS;
                     end else begin
                        phase_in = lvtp_pkg::PH_STOP;
                     end
                  end
                  lvtp_pkg::PH_PREFIX, lvtp_pkg::PH_DIGITS: begin
                     if (dg[4]) begin
                        acc_in   = taken;
                        phase_in = lvtp_pkg::PH_DIGITS;
                     end else begin
                        phase_in = lvtp_pkg::PH_STOP;
                     end
                  end
                  default: begin
                     phase_in = lvtp_pkg::PH_STOP;
                  end
               endcase
            end else begin
               if (cur_count < CW'(LABEL_CHARS)) store_we = 1'b1;
               if (cur_count <= CW'(LABEL_CHARS)) count_in = cur_count + CW'(1);
               else count_in = cur_count;
            end
         end
      end
      store_idx = cur_count[IW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff    <= 1'b0;
         expecting_ff <= 1'b0;
         pending_ff   <= 4'd0;
         count_ff     <= '0;
         acc_ff       <= 32'd0;
         neg_ff       <= 1'b0;
         phase_ff     <= lvtp_pkg::PH_SKIP;
      end else begin
         inside_ff    <= inside_in;
         expecting_ff <= expecting_in;
         pending_ff   <= pending_in;
         count_ff     <= count_in;
         acc_ff       <= acc_in;
         neg_ff       <= neg_in;
         phase_ff     <= phase_in;
      end
      if (store_we) store_ff[store_idx] <= step.text_byte;
   end

   assign value_signed = neg_ff ? (~acc_ff + 32'd1) : acc_ff;

   assign result.field_code  = pending_ff;
   assign result.field_value = (pending_ff == lvtp_pkg::CODE_CURRENT)
                               ? value_signed : {16'd0, value_signed[15:0]};

   `LVTP_ASSERT_NOW(a_emit_from_value, clock, reset, emit, inside_ff && expecting_ff)
   `LVTP_ASSERT_NOW(a_code_range, clock, reset, emit, result.field_code <= 4'd13)
   `LVTP_ASSERT_NOW(a_narrow_fields, clock, reset,
      emit && result.field_code != lvtp_pkg::CODE_CURRENT, result.field_value[31:16] == 16'd0)
   `LVTP_ASSERT_NEXT(a_end_of_text, clock, reset,
      step.fire && step.text_byte == lvtp_pkg::CH_NUL, !inside_ff && !expecting_ff)

endmodule

// File: src/lvtp_out_reg.sv
// Result register of the telemetry parser: holds one field until the sink takes it.
// Depends on lvtp_pkg.
module lvtp_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 emit,
   input  lvtp_pkg::result_type result,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output lvtp_pkg::result_type rsp_data,
   output logic                 out_free
);

   logic                 valid_ff, valid_in;
   lvtp_pkg::result_type data_ff, data_in;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (emit) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
